// File: hdl/rpnts_pkg.sv
`default_nettype none
package rpnts_pkg;

  localparam int LINE_LIMIT  = 1024;
  localparam int LINE_POS_W  = $clog2(LINE_LIMIT);
  localparam int LEN_W       = 10;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam int MAX_RES     = 3;
  localparam int CNT_W       = $clog2(MAX_RES + 1);
  localparam int IDX_W       = $clog2(MAX_RES);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_MAX    = 5;

  typedef enum logic [4:0] {
    TK_PROMPT, TK_NUM, TK_ADD, TK_SUB, TK_MUL, TK_DIV, TK_MOD, TK_ASSIGN,
    TK_VAR, TK_STACK, TK_DUP, TK_SWP, TK_CLR, TK_SIN, TK_EXP, TK_POW,
    TK_POP, TK_SET, TK_VLIST, TK_HELP, TK_INV, TK_END
  } tok_kind_t;

  typedef enum logic [2:0] {
    SM_IDLE, SM_NUM, SM_WORD, SM_MINUS, SM_DOT, SM_MDOT, SM_SKIP
  } scan_mode_t;

  typedef struct packed {
    logic       command;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    tok_kind_t        token_kind;
    logic [4:0]       variable_index;
    logic [LEN_W-1:0] token_length;
  } res_t;

  typedef struct packed {
    tok_kind_t        token_kind;
    logic [4:0]       variable_index;
    logic [LEN_W-1:0] token_length;
    logic             last;
  } out_item_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   cnt;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic res_t mk_res(tok_kind_t k, logic [4:0] v, logic [LEN_W-1:0] l);
    res_t r;
    r.token_kind     = k;
    r.variable_index = v;
    r.token_length   = l;
    return r;
  endfunction

  function automatic grp_t grp_put(grp_t g, res_t r);
    grp_t o;
    o = g;
    if (g.cnt < CNT_W'(MAX_RES)) begin
      o.res[g.cnt[IDX_W-1:0]] = r;
      o.cnt = g.cnt + CNT_W'(1);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// File: hdl/rpnts_front.sv
`default_nettype none
module rpnts_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire rpnts_pkg::in_item_t in_item,
  input  wire rpnts_pkg::q_stat_t q_stat,
  output logic                    q_push,
  output rpnts_pkg::grp_t         q_grp
);

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_Z   = 8'h7A;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [4:0] VAR_ANS = 5'd26;

  rpnts_pkg::scan_mode_t               mode_r, mode_nxt;
  logic [2:0]                          wc_r, wc_nxt;
  logic [rpnts_pkg::LEN_W-1:0]         len_r, len_nxt;
  logic [rpnts_pkg::LINE_POS_W-1:0]    lp_r, lp_nxt;
  logic [rpnts_pkg::WORD_MAX-1:0][7:0] letters_r, letters_nxt;

  rpnts_pkg::grp_t       g;
  rpnts_pkg::res_t       wr;
  logic [7:0]            c;
  logic                  is_ws, is_dig, do_start, do_skip, do_flush, accept;
  rpnts_pkg::scan_mode_t st_mode;
  logic                  st_len1, st_put, st_word;
  rpnts_pkg::tok_kind_t  st_kind;

  function automatic rpnts_pkg::res_t word_res(logic [2:0] wc,
      logic [rpnts_pkg::WORD_MAX-1:0][7:0] lt, logic [rpnts_pkg::LEN_W-1:0] len);
    rpnts_pkg::res_t r;
    logic [7:0]      d;
    d = lt[0] - CH_A;
    r = rpnts_pkg::mk_res(rpnts_pkg::TK_INV, 5'd0, len);
    if (wc == 3'd1) begin
      r.token_kind     = rpnts_pkg::TK_VAR;
      r.variable_index = d[4:0];
    end else if (wc == 3'd3 && {lt[0], lt[1], lt[2]} == "ans") begin
      r.token_kind     = rpnts_pkg::TK_VAR;
      r.variable_index = VAR_ANS;
    end else if (wc == 3'd3) begin
      if ({lt[0], lt[1], lt[2]} == "dup") r.token_kind = rpnts_pkg::TK_DUP;
      else if ({lt[0], lt[1], lt[2]} == "swp") r.token_kind = rpnts_pkg::TK_SWP;
      else if ({lt[0], lt[1], lt[2]} == "clr") r.token_kind = rpnts_pkg::TK_CLR;
      else if ({lt[0], lt[1], lt[2]} == "sin") r.token_kind = rpnts_pkg::TK_SIN;
      else if ({lt[0], lt[1], lt[2]} == "exp") r.token_kind = rpnts_pkg::TK_EXP;
      else if ({lt[0], lt[1], lt[2]} == "pow") r.token_kind = rpnts_pkg::TK_POW;
      else if ({lt[0], lt[1], lt[2]} == "pop") r.token_kind = rpnts_pkg::TK_POP;
      else if ({lt[0], lt[1], lt[2]} == "set") r.token_kind = rpnts_pkg::TK_SET;
    end else if (wc == 3'd4) begin
      if ({lt[0], lt[1], lt[2], lt[3]} == "help") r.token_kind = rpnts_pkg::TK_HELP;
    end else if (wc == 3'd5) begin
      if ({lt[0], lt[1], lt[2], lt[3], lt[4]} == "stack") begin
        r.token_kind = rpnts_pkg::TK_STACK;
      end else if ({lt[0], lt[1], lt[2], lt[3], lt[4]} == "vlist") begin
        r.token_kind = rpnts_pkg::TK_VLIST;
      end
    end
    return r;
  endfunction

  assign accept  = in_push && !q_stat.full;
  assign in_full = q_stat.full;
  assign c       = in_item.character;
  assign is_ws   = c == CH_SP || c == CH_TAB || c == CH_NL || c == CH_VT ||
                   c == CH_FF || c == CH_CR;
  assign is_dig  = c >= CH_0 && c <= CH_9;

  // how a character starts a fresh token
  always_comb begin
    st_mode = rpnts_pkg::SM_IDLE;
    st_len1 = 1'b1;
    st_put  = 1'b0;
    st_word = 1'b0;
    st_kind = rpnts_pkg::TK_PROMPT;
    priority if (c == CH_SP || c == CH_TAB) begin
      st_len1 = 1'b0;
    end else if (c == CH_NL) begin
      st_put  = 1'b1;
      st_len1 = 1'b0;
    end else if (is_dig) begin
      st_mode = rpnts_pkg::SM_NUM;
    end else if (c == ".") begin
      st_mode = rpnts_pkg::SM_DOT;
    end else if (c == "-") begin
      st_mode = rpnts_pkg::SM_MINUS;
    end else if (c == "+" || c == "*" || c == "/" || c == "%" || c == "=") begin
      st_put  = 1'b1;
      st_len1 = 1'b0;
      priority if (c == "+") st_kind = rpnts_pkg::TK_ADD;
      else if (c == "*") st_kind = rpnts_pkg::TK_MUL;
      else if (c == "/") st_kind = rpnts_pkg::TK_DIV;
      else if (c == "%") st_kind = rpnts_pkg::TK_MOD;
      else st_kind = rpnts_pkg::TK_ASSIGN;
    end else if (c >= CH_A && c <= CH_Z) begin
      st_mode = rpnts_pkg::SM_WORD;
      st_word = 1'b1;
    end else begin
      st_mode = rpnts_pkg::SM_SKIP;
    end
  end

  always_comb begin
    g           = '0;
    mode_nxt    = mode_r;
    wc_nxt      = wc_r;
    len_nxt     = len_r;
    lp_nxt      = lp_r;
    letters_nxt = letters_r;
    do_start    = 1'b0;
    do_skip     = 1'b0;
    do_flush    = 1'b0;
    wr          = word_res(wc_r, letters_r, len_r);
    if (!in_item.command) begin
      unique case (mode_r)
        rpnts_pkg::SM_NUM: begin
          if (is_ws) begin
            g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(rpnts_pkg::TK_NUM, 5'd0, len_nxt));
            do_start = 1'b1;
          end else if (len_nxt < rpnts_pkg::LEN_MAX) begin
            len_nxt = len_nxt + 1'b1;
          end
        end
        rpnts_pkg::SM_WORD: begin
          if (is_ws) begin
            if (wr.token_kind != rpnts_pkg::TK_INV) begin
              g = rpnts_pkg::grp_put(g, wr);
              do_start = 1'b1;
            end else begin
              mode_nxt = rpnts_pkg::SM_SKIP;
              do_skip  = 1'b1;
            end
          end else begin
            for (int i = 0; i < rpnts_pkg::WORD_MAX; i++) begin
              if (wc_nxt == 3'(i)) letters_nxt[i] = c;
            end
            if (wc_nxt < 3'd6) wc_nxt = wc_nxt + 3'd1;
            if (len_nxt < rpnts_pkg::LEN_MAX) len_nxt = len_nxt + 1'b1;
          end
        end
        rpnts_pkg::SM_MINUS: begin
          if (is_dig || c == ".") begin
            mode_nxt = is_dig ? rpnts_pkg::SM_NUM : rpnts_pkg::SM_MDOT;
            if (len_nxt < rpnts_pkg::LEN_MAX) len_nxt = len_nxt + 1'b1;
          end else begin
            g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(rpnts_pkg::TK_SUB, 5'd0,
                                                        rpnts_pkg::LEN_W'(1)));
            do_start = 1'b1;
          end
        end
        rpnts_pkg::SM_DOT: begin
          if (is_dig) begin
            mode_nxt = rpnts_pkg::SM_NUM;
            if (len_nxt < rpnts_pkg::LEN_MAX) len_nxt = len_nxt + 1'b1;
          end else begin
            mode_nxt = rpnts_pkg::SM_SKIP;
            do_skip  = 1'b1;
          end
        end
        rpnts_pkg::SM_MDOT: begin
          if (is_dig) begin
            mode_nxt = rpnts_pkg::SM_NUM;
            if (len_nxt < rpnts_pkg::LEN_MAX) len_nxt = len_nxt + 1'b1;
          end else begin
            g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(rpnts_pkg::TK_SUB, 5'd0,
                                                        rpnts_pkg::LEN_W'(1)));
            len_nxt  = rpnts_pkg::LEN_W'(1);
            mode_nxt = rpnts_pkg::SM_SKIP;
            do_skip  = 1'b1;
          end
        end
        rpnts_pkg::SM_SKIP: do_skip = 1'b1;
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        mode_nxt = st_mode;
        len_nxt  = st_len1 ? rpnts_pkg::LEN_W'(1) : '0;
        wc_nxt   = st_word ? 3'd1 : 3'd0;
        if (st_word) letters_nxt[0] = c;
        if (st_put) begin
          g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(st_kind, 5'd0, rpnts_pkg::LEN_W'(1)));
        end
      end

      if (do_skip) begin
        if (c == CH_NL) begin
          g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(rpnts_pkg::TK_INV, 5'd0, len_nxt));
          g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(rpnts_pkg::TK_PROMPT, 5'd0,
                                                      rpnts_pkg::LEN_W'(1)));
          mode_nxt = rpnts_pkg::SM_IDLE;
          len_nxt  = '0;
        end else if (len_nxt < rpnts_pkg::LEN_MAX) begin
          len_nxt = len_nxt + 1'b1;
        end
      end

      // line chunk limit
      if (c == CH_NL) begin
        lp_nxt = '0;
      end else begin
        lp_nxt = lp_nxt + 1'b1;
        if (lp_nxt >= rpnts_pkg::LINE_POS_W'(rpnts_pkg::LINE_LIMIT - 1)) begin
          do_flush = 1'b1;
          lp_nxt   = '0;
        end
      end
    end else begin
      do_flush = 1'b1;
      lp_nxt   = '0;
    end

    if (do_flush) begin
      wr = word_res(wc_nxt, letters_nxt, len_nxt);
      unique case (mode_nxt)
        rpnts_pkg::SM_NUM:
          g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(rpnts_pkg::TK_NUM, 5'd0, len_nxt));
        rpnts_pkg::SM_WORD: g = rpnts_pkg::grp_put(g, wr);
        rpnts_pkg::SM_MINUS:
          g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(rpnts_pkg::TK_SUB, 5'd0,
                                                      rpnts_pkg::LEN_W'(1)));
        rpnts_pkg::SM_DOT, rpnts_pkg::SM_SKIP:
          g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(rpnts_pkg::TK_INV, 5'd0, len_nxt));
        rpnts_pkg::SM_MDOT: begin
          g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(rpnts_pkg::TK_SUB, 5'd0,
                                                      rpnts_pkg::LEN_W'(1)));
          g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(rpnts_pkg::TK_INV, 5'd0,
                                                      rpnts_pkg::LEN_W'(1)));
        end
        default: ;
      endcase
      mode_nxt = rpnts_pkg::SM_IDLE;
      wc_nxt   = '0;
      len_nxt  = '0;
    end

    if (in_item.command) begin
      g = rpnts_pkg::grp_put(g, rpnts_pkg::mk_res(rpnts_pkg::TK_END, 5'd0, '0));
    end
  end

  assign q_push = accept && (g.cnt != '0);
  assign q_grp  = g;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rpnts_pkg::SM_IDLE;
      wc_r   <= '0;
      len_r  <= '0;
      lp_r   <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      wc_r   <= wc_nxt;
      len_r  <= len_nxt;
      lp_r   <= lp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) letters_r <= letters_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/rpnts_fifo.sv
`default_nettype none
module rpnts_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire rpnts_pkg::grp_t push_grp,
  input  wire logic            pop,
  output rpnts_pkg::grp_t      pop_grp,
  output rpnts_pkg::q_stat_t   stat
);

  rpnts_pkg::grp_t                entries_r [rpnts_pkg::QUEUE_DEPTH];
  logic [rpnts_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [rpnts_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                           do_push, do_pop;

  assign stat.full  = count_r == rpnts_pkg::QCNT_W'(rpnts_pkg::QUEUE_DEPTH);
  assign stat.empty = count_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_grp    = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == rpnts_pkg::QPTR_W'(rpnts_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == rpnts_pkg::QPTR_W'(rpnts_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_ptr_r] <= push_grp;
  end

endmodule
`default_nettype wire

// File: hdl/rpnts_back.sv
`default_nettype none
module rpnts_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rpnts_pkg::q_stat_t q_stat,
  input  wire rpnts_pkg::grp_t    q_grp,
  output logic                    q_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output rpnts_pkg::out_item_t    out_item
);

  rpnts_pkg::grp_t             cur_r, cur_nxt;
  logic [rpnts_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                        valid_r, valid_nxt;
  logic                        is_last, pop_fire, advance;
  rpnts_pkg::res_t             cur_res;

  assign cur_res  = cur_r.res[idx_r];
  assign is_last  = (rpnts_pkg::CNT_W'(idx_r) + rpnts_pkg::CNT_W'(1)) == cur_r.cnt;
  assign pop_fire = out_pop && valid_r;
  assign advance  = !valid_r || (pop_fire && is_last);
  assign q_pop    = advance && !q_stat.empty;

  assign out_empty               = !valid_r;
  assign out_item.token_kind     = cur_res.token_kind;
  assign out_item.variable_index = cur_res.variable_index;
  assign out_item.token_length   = cur_res.token_length;
  assign out_item.last           = is_last;

  always_comb begin
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = !q_stat.empty;
      idx_nxt   = '0;
      if (!q_stat.empty) cur_nxt = q_grp;
    end else if (pop_fire) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/rpn_calculator_token_scanner_top.sv
// path: an item's results are written into the queue, then loaded into the output stage that drives the out_ ports
// throughput: one item per cycle while the four-group queue has room; results leave
//   one per cycle, an item causing up to three, so the pop rate sets the pace
// reset: synchronous, active low on rst_n; clears scan state, queue and output stage
`default_nettype none
module rpn_calculator_token_scanner_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire rpnts_pkg::in_item_t in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output rpnts_pkg::out_item_t     out_item
);

  rpnts_pkg::q_stat_t q_stat;
  rpnts_pkg::grp_t    push_grp, pop_grp;
  logic               q_push, q_pop;

  rpnts_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_grp   (push_grp)
  );

  rpnts_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_grp (push_grp),
    .pop      (q_pop),
    .pop_grp  (pop_grp),
    .stat     (q_stat)
  );

  rpnts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_grp     (pop_grp),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// File: tb/rpn_calculator_token_scanner_top_tb.sv
`timescale 1ns / 100ps
module rpn_calculator_token_scanner_top_tb;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [4:0] VAR_NONE = 5'd0;
  localparam logic [rpnts_pkg::LEN_W-1:0] LEN_ONE = rpnts_pkg::LEN_W'(1);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  rpnts_pkg::in_item_t  in_item = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  rpnts_pkg::out_item_t out_item;

  rpn_calculator_token_scanner_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rpnts_pkg::in_item_t  stim_q[$];
  rpnts_pkg::out_item_t step_toks[$];
  rpnts_pkg::out_item_t pending_toks[$];
  int         queued_items = 0;
  int         mismatch_cnt = 0;
  bit         steady = 1'b0;
  logic       item_sent = 1'b0;
  int         hold_asks = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  // scanner state mirror
  rpnts_pkg::scan_mode_t       sc_mode = rpnts_pkg::SM_IDLE;
  logic [7:0]                  wd_chars [rpnts_pkg::WORD_MAX];
  int                          wd_len = 0;
  logic [rpnts_pkg::LEN_W-1:0] tok_len = '0;
  int                          line_chars = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == " " || c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic void emit(rpnts_pkg::tok_kind_t k, logic [4:0] v,
                               logic [rpnts_pkg::LEN_W-1:0] l);
    rpnts_pkg::out_item_t t;
    if (step_toks.size() < rpnts_pkg::MAX_RES) begin
      t.token_kind     = k;
      t.variable_index = v;
      t.token_length   = l;
      t.last           = 1'b0;
      step_toks.push_back(t);
    end
  endfunction

  function automatic void grow_len();
    if (tok_len != rpnts_pkg::LEN_MAX) tok_len = tok_len + 1'b1;
  endfunction

  function automatic rpnts_pkg::tok_kind_t word_kind(output logic [4:0] idx);
    logic [39:0]          w;
    rpnts_pkg::tok_kind_t k;
    idx = '0;
    if (wd_len == 1) begin
      idx = 5'(wd_chars[0] - "a");
      return rpnts_pkg::TK_VAR;
    end
    if (wd_len > rpnts_pkg::WORD_MAX) return rpnts_pkg::TK_INV;
    // first letter is never zero, so the packed value also fixes the length
    w = '0;
    for (int i = 0; i < wd_len; i++) w = {w[31:0], wd_chars[i]};
    k = rpnts_pkg::TK_INV;
    case (w)
      "ans": begin
        idx = 5'd26;
        k = rpnts_pkg::TK_VAR;
      end
      "stack": k = rpnts_pkg::TK_STACK;
      "dup":   k = rpnts_pkg::TK_DUP;
      "swp":   k = rpnts_pkg::TK_SWP;
      "clr":   k = rpnts_pkg::TK_CLR;
      "sin":   k = rpnts_pkg::TK_SIN;
      "exp":   k = rpnts_pkg::TK_EXP;
      "pow":   k = rpnts_pkg::TK_POW;
      "pop":   k = rpnts_pkg::TK_POP;
      "set":   k = rpnts_pkg::TK_SET;
      "vlist": k = rpnts_pkg::TK_VLIST;
      "help":  k = rpnts_pkg::TK_HELP;
      default: k = rpnts_pkg::TK_INV;
    endcase
    return k;
  endfunction

  function automatic void start_tok(logic [7:0] c);
    sc_mode = rpnts_pkg::SM_IDLE;
    tok_len = LEN_ONE;
    wd_len  = 0;
    if (c == " " || c == CH_TAB) tok_len = '0;
    else if (c == CH_NL) begin
      emit(rpnts_pkg::TK_PROMPT, VAR_NONE, LEN_ONE);
      tok_len = '0;
    end else if (is_digit(c)) sc_mode = rpnts_pkg::SM_NUM;
    else if (c == ".") sc_mode = rpnts_pkg::SM_DOT;
    else if (c == "-") sc_mode = rpnts_pkg::SM_MINUS;
    else if (c == "+" || c == "*" || c == "/" || c == "%" || c == "=") begin
      case (c)
        "+":     emit(rpnts_pkg::TK_ADD, VAR_NONE, LEN_ONE);
        "*":     emit(rpnts_pkg::TK_MUL, VAR_NONE, LEN_ONE);
        "/":     emit(rpnts_pkg::TK_DIV, VAR_NONE, LEN_ONE);
        "%":     emit(rpnts_pkg::TK_MOD, VAR_NONE, LEN_ONE);
        default: emit(rpnts_pkg::TK_ASSIGN, VAR_NONE, LEN_ONE);
      endcase
      tok_len = '0;
    end else if (c >= "a" && c <= "z") begin
      sc_mode = rpnts_pkg::SM_WORD;
      wd_chars[0] = c;
      wd_len = 1;
    end else sc_mode = rpnts_pkg::SM_SKIP;
  endfunction

  function automatic void skip_step(logic [7:0] c);
    if (c == CH_NL) begin
      emit(rpnts_pkg::TK_INV, VAR_NONE, tok_len);
      emit(rpnts_pkg::TK_PROMPT, VAR_NONE, LEN_ONE);
      sc_mode = rpnts_pkg::SM_IDLE;
      tok_len = '0;
    end else grow_len();
  endfunction

  function automatic void close_tok();
    rpnts_pkg::tok_kind_t k;
    logic [4:0]           v;
    case (sc_mode)
      rpnts_pkg::SM_NUM: emit(rpnts_pkg::TK_NUM, VAR_NONE, tok_len);
      rpnts_pkg::SM_WORD: begin
        k = word_kind(v);
        emit(k, v, tok_len);
      end
      rpnts_pkg::SM_MINUS: emit(rpnts_pkg::TK_SUB, VAR_NONE, LEN_ONE);
      rpnts_pkg::SM_DOT:   emit(rpnts_pkg::TK_INV, VAR_NONE, tok_len);
      rpnts_pkg::SM_MDOT: begin
        emit(rpnts_pkg::TK_SUB, VAR_NONE, LEN_ONE);
        emit(rpnts_pkg::TK_INV, VAR_NONE, LEN_ONE);
      end
      rpnts_pkg::SM_SKIP: emit(rpnts_pkg::TK_INV, VAR_NONE, tok_len);
      default: ;
    endcase
    sc_mode = rpnts_pkg::SM_IDLE;
    wd_len  = 0;
    tok_len = '0;
  endfunction

  function automatic void scan_item(rpnts_pkg::in_item_t it);
    logic [7:0]           c;
    rpnts_pkg::tok_kind_t k;
    logic [4:0]           v;
    step_toks.delete();
    if (it.command) begin
      close_tok();
      emit(rpnts_pkg::TK_END, VAR_NONE, '0);
      line_chars = 0;
    end else begin
      c = it.character;
      case (sc_mode)
        rpnts_pkg::SM_NUM: begin
          if (is_ws(c)) begin
            emit(rpnts_pkg::TK_NUM, VAR_NONE, tok_len);
            start_tok(c);
          end else grow_len();
        end
        rpnts_pkg::SM_WORD: begin
          if (is_ws(c)) begin
            k = word_kind(v);
            if (k != rpnts_pkg::TK_INV) begin
              emit(k, v, tok_len);
              start_tok(c);
            end else begin
              sc_mode = rpnts_pkg::SM_SKIP;
              skip_step(c);
            end
          end else begin
            if (wd_len < rpnts_pkg::WORD_MAX) wd_chars[wd_len] = c;
            if (wd_len <= rpnts_pkg::WORD_MAX) wd_len++;
            grow_len();
          end
        end
        rpnts_pkg::SM_MINUS: begin
          if (is_digit(c)) begin
            sc_mode = rpnts_pkg::SM_NUM;
            grow_len();
          end else if (c == ".") begin
            sc_mode = rpnts_pkg::SM_MDOT;
            grow_len();
          end else begin
            emit(rpnts_pkg::TK_SUB, VAR_NONE, LEN_ONE);
            start_tok(c);
          end
        end
        rpnts_pkg::SM_DOT: begin
          if (is_digit(c)) begin
            sc_mode = rpnts_pkg::SM_NUM;
            grow_len();
          end else begin
            sc_mode = rpnts_pkg::SM_SKIP;
            skip_step(c);
          end
        end
        rpnts_pkg::SM_MDOT: begin
          if (is_digit(c)) begin
            sc_mode = rpnts_pkg::SM_NUM;
            grow_len();
          end else begin
            emit(rpnts_pkg::TK_SUB, VAR_NONE, LEN_ONE);
            tok_len = LEN_ONE;
            sc_mode = rpnts_pkg::SM_SKIP;
            skip_step(c);
          end
        end
        rpnts_pkg::SM_SKIP: skip_step(c);
        default: start_tok(c);
      endcase
      // long line: chunk ends and scanning starts afresh
      if (c == CH_NL) line_chars = 0;
      else begin
        line_chars++;
        if (line_chars >= rpnts_pkg::LINE_LIMIT - 1) begin
          close_tok();
          line_chars = 0;
        end
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) pending_toks.push_back(step_toks[i]);
  endfunction

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || item_sent) begin
      if (stim_q.size() > 0 && (steady || $urandom_range(99) >= 35)) begin
        in_item <= stim_q.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= 300;
      out_pop <= 1'b0;
    end else begin
      out_pop <= steady || ($urandom_range(99) >= 35);
    end
  end

  // monitor
  always @(posedge clk) begin
    rpnts_pkg::out_item_t exp_tok;
    item_sent <= rst_n && in_push && !in_full;
    if (rst_n && in_push && !in_full) scan_item(in_item);
    if (rst_n && out_pop && !out_empty) begin
      if (pending_toks.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected token, got kind %0d var %0d len %0d last %0d", $time,
                 out_item.token_kind, out_item.variable_index, out_item.token_length,
                 out_item.last);
      end else begin
        exp_tok = pending_toks.pop_front();
        if (out_item !== exp_tok) begin
          mismatch_cnt++;
          $display({"%0t: token mismatch, expected kind %0d var %0d len %0d last %0d,",
                    " got kind %0d var %0d len %0d last %0d"},
                   $time, exp_tok.token_kind, exp_tok.variable_index, exp_tok.token_length,
                   exp_tok.last, out_item.token_kind, out_item.variable_index,
                   out_item.token_length, out_item.last);
        end
      end
    end
  end

  string word_list[12] = '{"ans", "stack", "dup", "swp", "clr", "sin", "exp", "pow",
                           "pop", "set", "vlist", "help"};

  task automatic push_item(logic cmd, logic [7:0] ch);
    rpnts_pkg::in_item_t it;
    it.command   = cmd;
    it.character = ch;
    stim_q.push_back(it);
    queued_items++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(1'b0, s[i]);
  endtask

  task automatic push_token();
    string s;
    int    n;
    case ($urandom_range(11))
      0, 1, 2: begin
        if ($urandom_range(2) == 0) push_item(1'b0, "-");
        if ($urandom_range(3) == 0) push_item(1'b0, ".");
        n = $urandom_range(1, 4);
        repeat (n) push_item(1'b0, 8'("0" + $urandom_range(9)));
        s = ".e+x";
        if ($urandom_range(3) == 0) push_item(1'b0, s[$urandom_range(3)]);
      end
      3: push_item(1'b0, 8'("a" + $urandom_range(25)));
      4, 5: push_text(word_list[$urandom_range(11)]);
      6: begin
        n = $urandom_range(2, 7);
        push_item(1'b0, 8'("a" + $urandom_range(25)));
        repeat (n - 1) begin
          if ($urandom_range(7) == 0) push_item(1'b0, 8'($urandom_range(33, 126)));
          else push_item(1'b0, 8'("a" + $urandom_range(25)));
        end
      end
      7: begin
        s = "+-*/%=";
        push_item(1'b0, s[$urandom_range(5)]);
      end
      8: begin
        // broken number starts
        s = "a+ -.";
        if ($urandom_range(1) == 0) push_item(1'b0, "-");
        push_item(1'b0, ".");
        if ($urandom_range(1) == 0) push_item(1'b0, s[$urandom_range(4)]);
      end
      9: push_item(1'b0, 8'($urandom_range(255)));
      10: begin
        push_item(1'b0, "-");
        if ($urandom_range(1) == 0) push_item(1'b0, 8'("a" + $urandom_range(25)));
      end
      default: begin
        push_item(1'b0, 8'("a" + $urandom_range(25)));
        push_item(1'b0, 8'($urandom_range(255)));
      end
    endcase
  endtask

  task automatic push_line();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      push_token();
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: push_item(1'b0, " ");
        6, 7:             push_item(1'b0, CH_TAB);
        8:                ;
        default: begin
          case ($urandom_range(2))
            0:       push_item(1'b0, CH_VT);
            1:       push_item(1'b0, CH_FF);
            default: push_item(1'b0, CH_CR);
          endcase
        end
      endcase
    end
    if ($urandom_range(19) == 0) push_item(1'b1, 8'($urandom));
    else push_item(1'b0, CH_NL);
  endtask

  task automatic push_lines(int n);
    int goal;
    goal = queued_items + n;
    while (queued_items < goal) push_line();
  endtask

  task automatic drain();
    while (stim_q.size() != 0 || in_push || pending_toks.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    push_text("-.\n");
    push_text("7 ans\t+\n");
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'hFF);
    push_text("\n-+\n-.");
    push_item(1'b1, 8'hFF);
    push_text("q");
    push_item(1'b1, 8'h00);
    drain();

    steady = 1'b1;
    push_lines(100);
    while (stim_q.size() != 0) @(posedge clk);
    steady = 1'b0;

    // receiver stalls while the sender keeps offering
    hold_asks++;
    push_lines(100);

    push_lines(110);
    push_lines(120);

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
